>>> src/slid_pkg.sv
// shared constants, codes and types for the sorted list insert/delete core
package slid_pkg;

  localparam int DEPTH       = 64;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int COUNT_OUT_W = 7;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef logic signed [VAL_W-1:0] value_t;

  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_ctrl_t;

endpackage

>>> src/slid_cell.sv
// one storage cell of the sorted chain: compares against the request and shifts with its neighbors
module slid_cell (
  input  logic                clk,
  input  slid_pkg::cell_ctrl_t ctrl,
  input  slid_pkg::value_t    req_value,
  input  logic                occupied,
  input  logic                left_take,
  input  slid_pkg::value_t    left_value,
  input  logic                right_eq,
  input  slid_pkg::value_t    right_value,
  output logic                take,
  output logic                eq,
  output slid_pkg::value_t    value_q,
  output slid_pkg::value_t    value_next
);

  logic gt;
  logic del_take;

  assign gt       = occupied && (value_q > req_value);
  assign eq       = occupied && (value_q == req_value);
  // insert: this cell sits at or after the insertion point
  assign take     = !occupied || (value_q > req_value);
  // delete: cells from the last equal entry upward pull from the right
  assign del_take = gt || (eq && !right_eq);

  always_comb begin
    value_next = value_q;
    if (ctrl.ins_en && take) begin
      value_next = left_take ? left_value : req_value;
    end else if (ctrl.del_en && del_take) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_q <= value_next;
  end

endmodule

>>> src/sorted_list_insert_delete_core.sv
// sorted multiset store: one request in, one result out (status, count, smallest)
// result: registered in the cycle after the request is accepted
// throughput: one request per cycle while the result side does not stall,
//   set by the compare-and-shift update that the whole cell chain registers at once
// reset: entry count and result valid clear; cell contents stay undefined,
//   no clearing pass, cells at or above the count never reach a result
module sorted_list_insert_delete_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  req_type,
  input  logic signed [slid_pkg::VAL_W-1:0]     value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            status,
  output logic [slid_pkg::COUNT_OUT_W-1:0]      entry_count,
  output logic signed [slid_pkg::VAL_W-1:0]     smallest
);

  logic                          accept;
  logic [slid_pkg::CNT_W-1:0]    count;
  logic [slid_pkg::CNT_W-1:0]    count_next;
  logic [slid_pkg::DEPTH-1:0]    occ;
  logic [slid_pkg::DEPTH-1:0]    take;
  logic [slid_pkg::DEPTH-1:0]    eq;
  slid_pkg::value_t              cell_val  [slid_pkg::DEPTH];
  slid_pkg::value_t              cell_next [slid_pkg::DEPTH];
  slid_pkg::cell_ctrl_t          ctrl;
  logic                          full;
  logic                          empty;
  logic                          found;
  logic [1:0]                    status_next;
  slid_pkg::value_t              smallest_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = (count == slid_pkg::CNT_W'(slid_pkg::DEPTH));
  assign empty = (count == '0);
  assign found = |eq;

  assign ctrl.ins_en = accept && (req_type == slid_pkg::REQ_INSERT) && !full;
  assign ctrl.del_en = accept && (req_type == slid_pkg::REQ_DELETE) && found;

  for (genvar i = 0; i < slid_pkg::DEPTH; i++) begin : g_cell
    logic             left_take;
    slid_pkg::value_t left_value;
    logic             right_eq;
    slid_pkg::value_t right_value;

    assign occ[i] = (count > slid_pkg::CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_take  = 1'b0;
      assign left_value = value;
    end else begin : g_mid_l
      assign left_take  = take[i-1];
      assign left_value = cell_val[i-1];
    end

    if (i == slid_pkg::DEPTH - 1) begin : g_last
      assign right_eq    = 1'b0;
      assign right_value = cell_val[i];
    end else begin : g_mid_r
      assign right_eq    = eq[i+1];
      assign right_value = cell_val[i+1];
    end

    slid_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .req_value   (value),
      .occupied    (occ[i]),
      .left_take   (left_take),
      .left_value  (left_value),
      .right_eq    (right_eq),
      .right_value (right_value),
      .take        (take[i]),
      .eq          (eq[i]),
      .value_q     (cell_val[i]),
      .value_next  (cell_next[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = slid_pkg::ST_DONE;
    if (req_type == slid_pkg::REQ_INSERT) begin
      if (full) begin
        status_next = slid_pkg::ST_FULL;
      end else begin
        count_next = count + slid_pkg::CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_next = slid_pkg::ST_EMPTY;
      end else if (!found) begin
        status_next = slid_pkg::ST_NOT_FOUND;
      end else begin
        count_next = count - slid_pkg::CNT_W'(1);
      end
    end
    smallest_next = (count_next != '0) ? cell_next[0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      entry_count <= slid_pkg::COUNT_OUT_W'(count_next);
      smallest    <= smallest_next;
    end
  end

endmodule

>>> src/slid_checker.sv
// port-level checks on the sorted list core, bound to the top level
module slid_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [1:0]                          status,
  input logic [slid_pkg::COUNT_OUT_W-1:0]    entry_count,
  input logic signed [slid_pkg::VAL_W-1:0]   smallest
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_count)
      && $stable(smallest))
    else $error("stalled result changed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= slid_pkg::COUNT_OUT_W'(slid_pkg::DEPTH))
    else $error("entry count above depth");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == slid_pkg::ST_EMPTY) |-> (entry_count == '0) && (smallest == '0))
    else $error("empty status with nonzero count or smallest");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == slid_pkg::ST_FULL)
      |-> entry_count == slid_pkg::COUNT_OUT_W'(slid_pkg::DEPTH))
    else $error("full status below depth");

  a_zero_smallest: assert property (@(posedge clk) disable iff (rst)
    out_valid && (entry_count == '0) |-> smallest == '0)
    else $error("smallest nonzero on empty store");

endmodule

bind sorted_list_insert_delete_core slid_checker u_slid_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .entry_count (entry_count),
  .smallest    (smallest)
);

>>> tb/tb_sorted_list_insert_delete_core.sv
// testbench for the sorted list insert/delete core: shadow sorted list, random requests and stalls
module tb_sorted_list_insert_delete_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]                       status;
    logic [slid_pkg::COUNT_OUT_W-1:0] entry_count;
    slid_pkg::value_t                 smallest;
  } list_result_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             req_type = slid_pkg::REQ_INSERT;
  slid_pkg::value_t                 value = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [1:0]                       status;
  logic [slid_pkg::COUNT_OUT_W-1:0] entry_count;
  slid_pkg::value_t                 smallest;

  slid_pkg::value_t shadow_list[$];
  list_result_t     awaited_results[$];
  list_result_t     want;
  int               error_count = 0;
  int               quiet_cycles = 0;
  bit               calm = 1'b0;

  sorted_list_insert_delete_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count),
    .smallest    (smallest)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic list_result_t apply_list_request(logic rt, slid_pkg::value_t v);
    list_result_t r;
    int           pos;
    r.status = slid_pkg::ST_DONE;
    pos = 0;
    if (rt == slid_pkg::REQ_INSERT) begin
      if (shadow_list.size() >= slid_pkg::DEPTH) begin
        r.status = slid_pkg::ST_FULL;
      end else begin
        while (pos < shadow_list.size() && shadow_list[pos] <= v) pos++;
        shadow_list.insert(pos, v);
      end
    end else if (shadow_list.size() == 0) begin
      r.status = slid_pkg::ST_EMPTY;
    end else begin
      while (pos < shadow_list.size() && shadow_list[pos] != v) pos++;
      if (pos >= shadow_list.size()) r.status = slid_pkg::ST_NOT_FOUND;
      else shadow_list.delete(pos);
    end
    r.entry_count = slid_pkg::COUNT_OUT_W'(shadow_list.size());
    r.smallest = (shadow_list.size() > 0) ? shadow_list[0] : '0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, exp_val);
    error_count++;
  endtask

  // one request, held until accepted
  task automatic send_request(input logic rt, input slid_pkg::value_t v);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    value    <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    awaited_results.push_back(apply_list_request(rt, v));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  function automatic slid_pkg::value_t pick_insert_value();
    int r;
    r = $urandom_range(99);
    if (r < 60) return slid_pkg::value_t'(int'($urandom_range(16)) - 8);
    if (r < 70) begin
      case ($urandom_range(3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return '0;
        default: return -1;
      endcase
    end
    return slid_pkg::value_t'($urandom);
  endfunction

  function automatic slid_pkg::value_t pick_delete_value();
    int r;
    r = $urandom_range(99);
    if (shadow_list.size() > 0 && r < 70)
      return shadow_list[$urandom_range(shadow_list.size() - 1)];
    if (r < 85) return slid_pkg::value_t'(int'($urandom_range(16)) - 8);
    return slid_pkg::value_t'($urandom);
  endfunction

  task automatic test_directed();
    send_request(slid_pkg::REQ_DELETE, '0);
    send_request(slid_pkg::REQ_DELETE, 32'sh8000_0000);
    send_request(slid_pkg::REQ_INSERT, 32'sh7fff_ffff);
    send_request(slid_pkg::REQ_INSERT, 32'sh8000_0000);
    send_request(slid_pkg::REQ_INSERT, '0);
    send_request(slid_pkg::REQ_INSERT, '0);
    send_request(slid_pkg::REQ_INSERT, -1);
    send_request(slid_pkg::REQ_INSERT, 1);
    send_request(slid_pkg::REQ_DELETE, 7);
    send_request(slid_pkg::REQ_DELETE, '0);
    send_request(slid_pkg::REQ_DELETE, '0);
    send_request(slid_pkg::REQ_DELETE, '0);
    send_request(slid_pkg::REQ_DELETE, 32'sh8000_0000);
    send_request(slid_pkg::REQ_DELETE, 32'sh7fff_ffff);
    send_request(slid_pkg::REQ_INSERT, 32'sh7fff_ffff);
    send_request(slid_pkg::REQ_INSERT, 32'sh7fff_ffff);
    send_request(slid_pkg::REQ_DELETE, 1);
    send_request(slid_pkg::REQ_DELETE, -1);
    send_request(slid_pkg::REQ_DELETE, 32'sh7fff_ffff);
    send_request(slid_pkg::REQ_DELETE, 32'sh7fff_ffff);
    send_request(slid_pkg::REQ_DELETE, 32'sh7fff_ffff);
    drain_results();
  endtask

  task automatic test_full_store();
    while (shadow_list.size() < slid_pkg::DEPTH)
      send_request(slid_pkg::REQ_INSERT,
                   slid_pkg::value_t'(int'($urandom_range(200)) - 100));
    send_request(slid_pkg::REQ_INSERT, 32'sh8000_0000);
    send_request(slid_pkg::REQ_INSERT, 32'sh7fff_ffff);
    send_request(slid_pkg::REQ_DELETE, 32'sh7fff_ffff);
    send_request(slid_pkg::REQ_INSERT, '0);
    drain_results();
    while (shadow_list.size() > 0)
      send_request(slid_pkg::REQ_DELETE,
                   shadow_list[$urandom_range(shadow_list.size() - 1)]);
    send_request(slid_pkg::REQ_DELETE, '0);
    drain_results();
  endtask

  task automatic test_random_mix(input int items, input int insert_pct, input bit no_idle);
    calm = no_idle;
    repeat (items) begin
      if ($urandom_range(99) < insert_pct)
        send_request(slid_pkg::REQ_INSERT, pick_insert_value());
      else send_request(slid_pkg::REQ_DELETE, pick_delete_value());
    end
    drain_results();
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 25);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with none pending", {30'b0, status}, '0);
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
          if (entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(entry_count), 32'(want.entry_count));
          if (smallest !== want.smallest) report_mismatch("smallest", smallest, want.smallest);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_random_mix(250, 75, 1'b0);
    test_random_mix(250, 30, 1'b0);
    test_random_mix(200, 70, 1'b1);
    test_random_mix(250, 25, 1'b0);
    test_random_mix(150, 55, 1'b0);
    drain_results();
    repeat (4) @(posedge clk);
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
